/* rtl/lhd_pkg.sv */
// ---------------------------------------------------------------------------
// lhd_pkg: shared types and constants for the LZ/Huffman stream decoder
// Action and status codes, queue item layout and memory geometry.
// ---------------------------------------------------------------------------
package lhd_pkg;

   // input action codes
   localparam logic [2:0] ACT_SYM_LOAD  = 3'd0;
   localparam logic [2:0] ACT_DIST_LOAD = 3'd1;
   localparam logic [2:0] ACT_START     = 3'd2;
   localparam logic [2:0] ACT_BIT       = 3'd3;
   localparam logic [2:0] ACT_PULL      = 3'd4;
   localparam logic [2:0] ACT_END       = 3'd5;

   // result status codes
   localparam logic [2:0] ST_BYTE      = 3'd0;
   localparam logic [2:0] ST_TRUNC     = 3'd1;
   localparam logic [2:0] ST_LEAF_OOR  = 3'd2;
   localparam logic [2:0] ST_OVERRUN   = 3'd3;
   localparam logic [2:0] ST_OFS_LARGE = 3'd4;
   localparam logic [2:0] ST_REF_EARLY = 3'd5;
   localparam logic [2:0] ST_REF_LATE  = 3'd6;

   // memory geometry
   localparam int SYM_DEPTH     = 1024;
   localparam int DIST_DEPTH    = 64;
   localparam int HISTORY_BYTES = 65536;
   localparam int HIST_AW       = $clog2(HISTORY_BYTES);

   // classified item kinds
   typedef enum logic [5:0] {
      K_SYM_LOAD  = 6'b000001,
      K_DIST_LOAD = 6'b000010,
      K_START     = 6'b000100,
      K_BIT       = 6'b001000,
      K_PULL      = 6'b010000,
      K_END       = 6'b100000
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [9:0]  entry_index;
      logic [8:0]  entry_value;
      logic [9:0]  symbol_entries;
      logic [5:0]  distance_entries;
      logic [31:0] out_size;
      logic        compressed_bit;
   } item_type;

endpackage

/* rtl/lhd_if.sv */
// ---------------------------------------------------------------------------
// lhd request / response channels
// Valid/ready channels carrying the decoder's input and result transactions.
// ---------------------------------------------------------------------------
interface lhd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [9:0]  entry_index;
   logic [8:0]  entry_value;
   logic [9:0]  symbol_entries;
   logic [5:0]  distance_entries;
   logic [31:0] out_size;
   logic        compressed_bit;

   modport source (output valid, action, entry_index, entry_value, symbol_entries,
                   distance_entries, out_size, compressed_bit, input ready);
   modport sink   (input valid, action, entry_index, entry_value, symbol_entries,
                   distance_entries, out_size, compressed_bit, output ready);
endinterface

interface lhd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic       last;

   modport source (output valid, out_byte, status, last, input ready);
   modport sink   (input valid, out_byte, status, last, output ready);
endinterface

/* rtl/lz_huffman_stream_decoder_unit.sv */
// ---------------------------------------------------------------------------
// lz_huffman_stream_decoder_unit: LZ77 + Huffman stream decoder
// Tree-walking bit decoder with a 64 KiB history copy engine.
// ---------------------------------------------------------------------------
// A two-entry queue takes request transactions while the back end works.
// Tree loads and start are taken straight from the queue; a compressed bit that
// steps to an inner node passes through S_NODE (tree memory read of the current
// node), one that reaches a leaf goes on to S_LEAF (a second read for the leaf
// entry), and the final extra bit of a distance is finished in S_HIST. A pull goes
// through S_HIST and the registered history read. While a result waits in the output
// register the queue keeps filling, but the back end holds every compressed bit, pull
// and end-of-input transaction until that result has been taken.
module lz_huffman_stream_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   lhd_req_if.sink    req,
   lhd_rsp_if.source  rsp
);

   logic              q_valid;
   logic              q_pop;
   lhd_pkg::item_type q_item;

   lhd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   lhd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

   // an error transaction always closes the stream
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != lhd_pkg::ST_BYTE |-> rsp.last)
      else $error("error result without last");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp.valid)
      else $error("result valid after reset");

   // queue is never popped when empty
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule

/* rtl/lhd_front.sv */
// ---------------------------------------------------------------------------
// lhd_front: input classification and item queue
// Decodes the action of each request transaction and queues the known ones (2 deep).
// ---------------------------------------------------------------------------
module lhd_front (
   input  logic              clock,
   input  logic              reset,
   lhd_req_if.sink           req,
   output logic              q_valid,
   output lhd_pkg::item_type q_item,
   input  logic              q_pop
);

   lhd_pkg::item_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   lhd_pkg::item_type new_item;
   logic              known;
   logic              push;

   // classify the action; unused codes are dropped
   always_comb begin
      known         = 1'b1;
      new_item.kind = lhd_pkg::K_SYM_LOAD;
      unique case (req.action)
         lhd_pkg::ACT_SYM_LOAD:  new_item.kind = lhd_pkg::K_SYM_LOAD;
         lhd_pkg::ACT_DIST_LOAD: new_item.kind = lhd_pkg::K_DIST_LOAD;
         lhd_pkg::ACT_START:     new_item.kind = lhd_pkg::K_START;
         lhd_pkg::ACT_BIT:       new_item.kind = lhd_pkg::K_BIT;
         lhd_pkg::ACT_PULL:      new_item.kind = lhd_pkg::K_PULL;
         lhd_pkg::ACT_END:       new_item.kind = lhd_pkg::K_END;
         default:                known = 1'b0;
      endcase
      new_item.entry_index      = req.entry_index;
      new_item.entry_value      = req.entry_value;
      new_item.symbol_entries   = req.symbol_entries;
      new_item.distance_entries = req.distance_entries;
      new_item.out_size         = req.out_size;
      new_item.compressed_bit   = req.compressed_bit;
   end

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready && known;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* rtl/lhd_back.sv */
// ---------------------------------------------------------------------------
// lhd_back: tree walker, copy engine and result register
// Executes queued items against the trees and history memories.
// ---------------------------------------------------------------------------
module lhd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lhd_pkg::item_type q_item,
   output logic              q_pop,
   lhd_rsp_if.source         rsp
);

   localparam int AW = lhd_pkg::HIST_AW;

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_SYM   = 7'b0000010,
      PH_DIST  = 7'b0000100,
      PH_EXTRA = 7'b0001000,
      PH_COPY  = 7'b0010000,
      PH_DONE  = 7'b0100000,
      PH_ERROR = 7'b1000000
   } phase_type;

   typedef enum logic [3:0] {
      S_TAKE = 4'b0001,
      S_NODE = 4'b0010,
      S_LEAF = 4'b0100,
      S_HIST = 4'b1000
   } st_type;

   // memories
   logic [8:0] sym_mem  [lhd_pkg::SYM_DEPTH];
   logic [4:0] dist_mem [lhd_pkg::DIST_DEPTH];
   logic [7:0] hist_mem [lhd_pkg::HISTORY_BYTES];
   logic [8:0] sym_rd_ff;
   logic [4:0] dist_rd_ff;
   logic [7:0] hist_rd_ff;

   logic          sym_we, sym_re, dist_we, dist_re, hist_we, hist_re;
   logic [9:0]    sym_waddr, sym_raddr;
   logic [5:0]    dist_waddr, dist_raddr;
   logic [AW-1:0] hist_waddr, hist_raddr;
   logic [8:0]    sym_wdata;
   logic [4:0]    dist_wdata;
   logic [7:0]    hist_wdata;

   // state
   st_type      st_ff, st_in;
   phase_type   phase_ff, phase_in;
   logic [9:0]  node_ff, node_in;
   logic [8:0]  cpl_ff, cpl_in;
   logic [16:0] coff_ff, coff_in;
   logic [4:0]  extra_ff, extra_in;
   logic [31:0] opos_ff, opos_in;
   logic [9:0]  scnt_ff, scnt_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [31:0] total_ff, total_in;
   logic [15:0] acc_ff, acc_in;
   logic        bit_ff, bit_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        out_free;
   logic        emitting;
   logic        in_sym;
   logic [6:0]  child_ofs;
   logic        leaf_flag;
   logic [10:0] target;
   logic [10:0] limit;
   logic [4:0]  extra_dec;
   logic [15:0] acc_shift;
   logic [15:0] fin_acc;
   logic [16:0] fin_dist;
   logic        fin_large, fin_early, fin_late;
   logic [31:0] opos_inc;
   logic        at_end;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign in_sym   = (phase_ff == PH_SYM);
   assign opos_inc = opos_ff + 32'd1;
   assign at_end   = (opos_inc == total_ff);

   // tree step arithmetic on the node entry just read
   always_comb begin
      if (in_sym) begin
         child_ofs = sym_rd_ff[6:0];
         leaf_flag = bit_ff ? sym_rd_ff[7] : sym_rd_ff[8];
         limit     = {1'b0, scnt_ff} + 11'd1;
      end else begin
         child_ofs = {4'd0, dist_rd_ff[2:0]};
         leaf_flag = bit_ff ? dist_rd_ff[3] : dist_rd_ff[4];
         limit     = {5'd0, dcnt_ff} + 11'd1;
      end
      target = {1'b0, node_ff[9:1], 1'b0} + {2'd0, ({1'b0, child_ofs} + 8'd1), 1'b0}
               + {10'd0, bit_ff};
   end

   // offset completion checks
   assign extra_dec = extra_ff - 5'd1;
   assign acc_shift = {acc_ff[14:0], bit_ff};
   always_comb begin
      if (st_ff == S_LEAF) begin
         fin_acc = (dist_rd_ff == 5'd0) ? 16'd0 : 16'd1;
      end else begin
         fin_acc = acc_shift;
      end
      fin_dist  = {1'b0, fin_acc} + 17'd1;
      fin_large = (fin_acc == 16'hFFFF);
      fin_early = (opos_ff < {15'd0, fin_dist});
      fin_late  = ({1'b0, opos_ff} + {24'd0, cpl_ff}) > {1'b0, total_ff};
   end

   // sequencer
   always_comb begin
      st_in    = st_ff;
      phase_in = phase_ff;
      node_in  = node_ff;
      cpl_in   = cpl_ff;
      coff_in  = coff_ff;
      extra_in = extra_ff;
      opos_in  = opos_ff;
      scnt_in  = scnt_ff;
      dcnt_in  = dcnt_ff;
      total_in = total_ff;
      acc_in   = acc_ff;
      bit_in   = bit_ff;
      q_pop    = 1'b0;
      sym_we = 1'b0; sym_waddr = q_item.entry_index; sym_wdata = q_item.entry_value;
      dist_we = 1'b0; dist_waddr = q_item.entry_index[5:0];
      dist_wdata = q_item.entry_value[4:0];
      sym_re = 1'b0; sym_raddr = node_ff;
      dist_re = 1'b0; dist_raddr = node_ff[5:0];
      hist_re = 1'b0; hist_raddr = opos_ff[AW-1:0] - coff_ff[AW-1:0];
      hist_we = 1'b0; hist_waddr = opos_ff[AW-1:0]; hist_wdata = sym_rd_ff[7:0];
      emitting      = 1'b0;
      rsp_byte_in   = 8'd0;
      rsp_status_in = lhd_pkg::ST_BYTE;
      rsp_last_in   = 1'b1;

      unique case (st_ff)
         S_TAKE: begin
            if (q_valid) begin
               unique case (q_item.kind)
                  lhd_pkg::K_SYM_LOAD: begin
                     q_pop  = 1'b1;
                     sym_we = 1'b1;
                  end
                  lhd_pkg::K_DIST_LOAD: begin
                     q_pop   = 1'b1;
                     dist_we = (q_item.entry_index[9:6] == 4'd0);
                  end
                  lhd_pkg::K_START: begin
                     q_pop    = 1'b1;
                     scnt_in  = q_item.symbol_entries;
                     dcnt_in  = q_item.distance_entries;
                     total_in = q_item.out_size;
                     opos_in  = 32'd0;
                     node_in  = 10'd1;
                     cpl_in   = 9'd0;
                     coff_in  = 17'd0;
                     extra_in = 5'd0;
                     acc_in   = 16'd0;
                     phase_in = (q_item.out_size == 32'd0) ? PH_DONE : PH_SYM;
                  end
                  lhd_pkg::K_BIT: begin
                     if (out_free) begin
                        q_pop  = 1'b1;
                        bit_in = q_item.compressed_bit;
                        if (phase_ff == PH_SYM) begin
                           sym_re = 1'b1;
                           st_in  = S_NODE;
                        end else if (phase_ff == PH_DIST) begin
                           dist_re = 1'b1;
                           st_in   = S_NODE;
                        end else if (phase_ff == PH_EXTRA) begin
                           bit_in   = bit_ff;
                           acc_in   = {acc_ff[14:0], q_item.compressed_bit};
                           extra_in = extra_dec;
                           // acc_shift uses bit_ff, so settle in S_LEAF-free form
                           if (extra_dec != 5'd0) begin
                              if (q_item.compressed_bit == 1'b0 && acc_ff[14] == 1'b0) begin
                              end else if (acc_ff[14]) begin
                                 emitting      = 1'b1;
                                 rsp_status_in = lhd_pkg::ST_OFS_LARGE;
                                 phase_in      = PH_ERROR;
                                 node_in       = 10'd1;
                              end
                           end else begin
                              q_pop  = 1'b0;
                              bit_in = q_item.compressed_bit;
                              st_in  = S_HIST;
                              acc_in = acc_ff;
                              extra_in = extra_ff;
                              // finish in S_HIST with the bit registered
                           end
                        end
                     end
                  end
                  lhd_pkg::K_PULL: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        if (phase_ff == PH_COPY) begin
                           hist_re = 1'b1;
                           st_in   = S_HIST;
                        end
                     end
                  end
                  lhd_pkg::K_END: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        if (phase_ff == PH_SYM || phase_ff == PH_DIST ||
                            phase_ff == PH_EXTRA) begin
                           emitting      = 1'b1;
                           rsp_status_in = lhd_pkg::ST_TRUNC;
                           phase_in      = PH_ERROR;
                           node_in       = 10'd1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_NODE: begin
            if (target >= limit) begin
               if (out_free) begin
                  emitting      = 1'b1;
                  rsp_status_in = leaf_flag ? lhd_pkg::ST_LEAF_OOR : lhd_pkg::ST_OVERRUN;
                  phase_in      = PH_ERROR;
                  node_in       = 10'd1;
                  st_in         = S_TAKE;
               end
            end else if (leaf_flag) begin
               node_in    = 10'd1;
               sym_re     = in_sym;
               dist_re    = !in_sym;
               sym_raddr  = target[9:0];
               dist_raddr = target[5:0];
               st_in      = S_LEAF;
            end else begin
               node_in = target[9:0];
               st_in   = S_TAKE;
            end
         end

         S_LEAF: begin
            if (out_free) begin
               st_in = S_TAKE;
               if (in_sym) begin
                  if (sym_rd_ff[8] == 1'b0) begin
                     emitting    = 1'b1;
                     rsp_byte_in = sym_rd_ff[7:0];
                     rsp_last_in = at_end;
                     hist_we     = 1'b1;
                     opos_in     = opos_inc;
                     if (at_end) phase_in = PH_DONE;
                  end else begin
                     cpl_in   = {1'b0, sym_rd_ff[7:0]} + 9'd3;
                     phase_in = PH_DIST;
                  end
               end else if (dist_rd_ff > 5'd1) begin
                  acc_in   = 16'd1;
                  extra_in = dist_rd_ff - 5'd1;
                  phase_in = PH_EXTRA;
               end else begin
                  acc_in = fin_acc;
                  if (fin_large || fin_early || fin_late) begin
                     emitting      = 1'b1;
                     rsp_status_in = fin_large ? lhd_pkg::ST_OFS_LARGE :
                                     fin_early ? lhd_pkg::ST_REF_EARLY :
                                                 lhd_pkg::ST_REF_LATE;
                     phase_in      = PH_ERROR;
                     node_in       = 10'd1;
                  end else begin
                     coff_in  = fin_dist;
                     extra_in = 5'd0;
                     phase_in = PH_COPY;
                  end
               end
            end
         end

         S_HIST: begin
            if (out_free) begin
               st_in = S_TAKE;
               if (phase_ff == PH_EXTRA) begin
                  // last extra bit: finish the offset
                  q_pop    = 1'b1;
                  acc_in   = fin_acc;
                  extra_in = 5'd0;
                  if (fin_large || fin_early || fin_late) begin
                     emitting      = 1'b1;
                     rsp_status_in = fin_large ? lhd_pkg::ST_OFS_LARGE :
                                     fin_early ? lhd_pkg::ST_REF_EARLY :
                                                 lhd_pkg::ST_REF_LATE;
                     phase_in      = PH_ERROR;
                     node_in       = 10'd1;
                  end else begin
                     coff_in  = fin_dist;
                     phase_in = PH_COPY;
                  end
               end else begin
                  // copy byte
                  emitting    = 1'b1;
                  rsp_byte_in = hist_rd_ff;
                  rsp_last_in = at_end;
                  hist_we     = 1'b1;
                  hist_wdata  = hist_rd_ff;
                  opos_in     = opos_inc;
                  cpl_in      = cpl_ff - 9'd1;
                  if (at_end) begin
                     phase_in = PH_DONE;
                  end else if (cpl_ff == 9'd1) begin
                     phase_in = PH_SYM;
                     node_in  = 10'd1;
                  end
               end
            end
         end

         default: st_in = S_TAKE;
      endcase

      rsp_valid_in = emitting ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_TAKE;
         phase_ff     <= PH_IDLE;
         node_ff      <= 10'd1;
         cpl_ff       <= 9'd0;
         coff_ff      <= 17'd0;
         extra_ff     <= 5'd0;
         opos_ff      <= 32'd0;
         scnt_ff      <= 10'd0;
         dcnt_ff      <= 6'd0;
         total_ff     <= 32'd0;
         acc_ff       <= 16'd0;
         bit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         node_ff      <= node_in;
         cpl_ff       <= cpl_in;
         coff_ff      <= coff_in;
         extra_ff     <= extra_in;
         opos_ff      <= opos_in;
         scnt_ff      <= scnt_in;
         dcnt_ff      <= dcnt_in;
         total_ff     <= total_in;
         acc_ff       <= acc_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emitting) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // tree and history memories
   always_ff @(posedge clock) begin
      if (sym_we) sym_mem[sym_waddr] <= sym_wdata;
      if (sym_re) sym_rd_ff <= sym_mem[sym_raddr];
   end

   always_ff @(posedge clock) begin
      if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
      if (dist_re) dist_rd_ff <= dist_mem[dist_raddr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      if (hist_re) hist_rd_ff <= hist_mem[hist_raddr];
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.last     = rsp_last_ff;

endmodule
